FILE: rtl/vbme_pkg.sv
package vbme_pkg;

   localparam int DeltaBitsDefault = 28;
   localparam int DeltaMaxBits     = 28;   // four 7-bit groups at most
   localparam int ChanBits         = 4;
   localparam int SlotCount        = 11;   // 4 delta + status + 2 data + 4 end-of-track
   localparam int PayloadSlots     = 7;

   // parse phases
   localparam logic [2:0] PhaseSkip       = 3'd0;
   localparam logic [2:0] PhaseDeltaStart = 3'd1;
   localparam logic [2:0] PhaseDeltaMore  = 3'd2;
   localparam logic [2:0] PhaseStatus     = 3'd3;
   localparam logic [2:0] PhaseData1      = 3'd4;
   localparam logic [2:0] PhaseData2      = 3'd5;

   // stream byte codes
   localparam logic [7:0] ByteTiming   = 8'hf8;
   localparam logic [7:0] ByteEnd      = 8'hfc;
   localparam logic [7:0] TimingDelta  = 8'd240;
   localparam logic [3:0] HiNoteOn     = 4'h9;
   localparam logic [3:0] HiNoteOff    = 4'h8;
   localparam logic [3:0] HiControl    = 4'hb;
   localparam logic [3:0] HiPatch      = 4'hc;
   localparam logic [3:0] HiPitch      = 4'he;
   localparam logic [7:0] EotByte0     = 8'h00;
   localparam logic [7:0] EotByte1     = 8'hff;
   localparam logic [7:0] EotByte2     = 8'h2f;
   localparam logic [7:0] EotByte3     = 8'h00;

   // error codes
   localparam logic [1:0] ErrNone      = 2'd0;
   localparam logic [1:0] ErrChannel   = 2'd1;
   localparam logic [1:0] ErrNoStatus  = 2'd2;
   localparam logic [1:0] ErrTruncated = 2'd3;

   // slot positions in one output burst
   localparam logic [3:0] SlotStatus = 4'd4;
   localparam logic [3:0] SlotData1  = 4'd5;
   localparam logic [3:0] SlotData2  = 4'd6;
   localparam logic [3:0] SlotEot0   = 4'd7;
   localparam logic [3:0] SlotEot1   = 4'd8;
   localparam logic [3:0] SlotEot2   = 4'd9;
   localparam logic [3:0] SlotEot3   = 4'd10;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       voice_start;
      logic       voice_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic [1:0] error_code;
      logic       track_done;
   } rsp_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [7:0] running_status;
      logic [7:0] first_data;
      logic       stream_ended;
   } parse_state_type;

   typedef struct packed {
      logic [SlotCount-1:0]         mask;
      logic [PayloadSlots-1:0][7:0] slot_byte;
      logic [1:0]                   error_code;
   } burst_type;

endpackage

FILE: rtl/vbme_parse.sv
module vbme_parse #(
   parameter int DELTA_BITS = vbme_pkg::DeltaBitsDefault
) (
   input  vbme_pkg::req_type         req_data,
   input  logic [vbme_pkg::ChanBits-1:0] voice_channel,
   input  vbme_pkg::parse_state_type state,
   input  logic [DELTA_BITS-1:0]     delta,
   output vbme_pkg::parse_state_type state_next,
   output logic [DELTA_BITS-1:0]     delta_next,
   output vbme_pkg::burst_type       burst
);
   import vbme_pkg::*;

   logic [7:0]              b;
   logic [3:0]              rs_hi;
   logic                    is_status;
   logic [7:0]              add_val;
   logic [DELTA_BITS:0]     sum;
   logic [DELTA_BITS-1:0]   delta_sat;
   logic                    tf_wait;
   logic                    tf_patch;
   logic                    ev;
   logic                    ev_three;
   logic [7:0]              ev_st;
   logic [7:0]              ev_d1;
   logic [7:0]              ev_d2;
   logic                    eot;
   logic [1:0]              err;
   logic [DeltaMaxBits-1:0] ext;

   assign b       = req_data.in_byte;
   assign rs_hi   = state.running_status[7:4];
   assign is_status = (b[7:4] == HiNoteOn) || (b[7:4] == HiControl) ||
                      (b[7:4] == HiPatch)  || (b[7:4] == HiPitch);
   assign add_val = (b == ByteTiming) ? TimingDelta : b;
   assign sum     = {1'b0, delta} + (DELTA_BITS+1)'(add_val);
   // carry out means past the cap
   assign delta_sat = sum[DELTA_BITS] ? '1 : sum[DELTA_BITS-1:0];
   assign tf_wait  = (rs_hi == HiNoteOn) || (rs_hi == HiControl) || (rs_hi == HiPitch);
   assign tf_patch = (rs_hi == HiPatch);

   always_comb begin
      state_next = state;
      delta_next = delta;
      ev         = 1'b0;
      ev_three   = 1'b0;
      ev_st      = state.running_status;
      ev_d1      = b;
      ev_d2      = b;
      eot        = 1'b0;
      err        = ErrNone;

      if (req_data.voice_start) begin
         state_next.phase          = PhaseDeltaStart;
         state_next.running_status = '0;
         state_next.first_data     = '0;
         state_next.stream_ended   = 1'b0;
         delta_next                = '0;
      end else if (!state.stream_ended) begin
         unique case (state.phase) inside
            PhaseSkip: state_next.phase = PhaseDeltaStart;
            PhaseDeltaStart, PhaseDeltaMore: begin
               delta_next       = delta_sat;
               state_next.phase = (b == ByteTiming) ? PhaseDeltaMore : PhaseStatus;
            end
            PhaseStatus, PhaseData1: begin
               if (state.phase == PhaseStatus && is_status) begin
                  if (b[3:0] != voice_channel) begin
                     err = ErrChannel;
                  end else begin
                     state_next.running_status = b;
                     state_next.phase          = PhaseData1;
                  end
               end else if (state.phase == PhaseStatus && b == ByteEnd) begin
                  eot = 1'b1;
               end else if (tf_wait) begin
                  state_next.first_data = b;
                  state_next.phase      = PhaseData2;
               end else if (tf_patch) begin
                  ev = 1'b1;
               end else begin
                  err = ErrNoStatus;
               end
            end
            PhaseData2: begin
               ev       = 1'b1;
               ev_three = 1'b1;
               ev_d1    = state.first_data;
               // note on with zero velocity goes out as note off
               if (rs_hi == HiNoteOn && b == 8'd0) begin
                  ev_st = {HiNoteOff, voice_channel};
               end
            end
            default: state_next.phase = PhaseDeltaStart;
         endcase

         if (ev) begin
            delta_next       = '0;
            state_next.phase = PhaseDeltaStart;
         end
         if (eot || err != ErrNone) begin
            state_next.stream_ended = 1'b1;
         end
      end

      // buffer end: close the track between events, flag a cut event otherwise
      if (req_data.voice_end && !state_next.stream_ended) begin
         state_next.stream_ended = 1'b1;
         if (state_next.phase == PhaseDeltaStart) begin
            eot = 1'b1;
         end else begin
            err = ErrTruncated;
         end
      end
   end

   assign ext = DeltaMaxBits'(delta);

   always_comb begin
      burst.slot_byte[0] = {1'b1, ext[27:21]};
      burst.slot_byte[1] = {1'b1, ext[20:14]};
      burst.slot_byte[2] = {1'b1, ext[13:7]};
      burst.slot_byte[3] = {1'b0, ext[6:0]};
      burst.slot_byte[4] = (err != ErrNone) ? 8'd0 : ev_st;
      burst.slot_byte[5] = ev_d1;
      burst.slot_byte[6] = ev_d2;
      burst.error_code   = err;
      burst.mask[0]      = ev && (ext[27:21] != '0);
      burst.mask[1]      = ev && (ext[27:14] != '0);
      burst.mask[2]      = ev && (ext[27:7]  != '0);
      burst.mask[3]      = ev;
      burst.mask[4]      = ev || (err != ErrNone);
      burst.mask[5]      = ev;
      burst.mask[6]      = ev && ev_three;
      burst.mask[7]      = eot;
      burst.mask[8]      = eot;
      burst.mask[9]      = eot;
      burst.mask[10]     = eot;
   end

endmodule

FILE: rtl/voice_bytes_to_midi_events_unit.sv
// Channel  Direction  Ports                              Moves
// req      in         req_valid, req_ready, req_data     one voice stream byte
// rsp      out        rsp_valid, rsp_ready, rsp_data     one MIDI track byte
// csr      in         csr_valid, csr_ready, csr_data     voice channel (always ready)
//
// A req transaction is parsed in the cycle it is taken; its output bytes (0 to 11)
// are held in one burst register and leave one per cycle while rsp_ready is
// high, lowest slot first. The single rsp byte port paces the items.
// req_ready is high while the burst register is empty or its last byte leaves,
// so the next byte is taken in the same cycle the previous burst drains.
// Synchronous active-high reset: parser in skip-first-byte phase, delta and
// running status cleared, channel 0, burst empty. No clearing pass.
module voice_bytes_to_midi_events_unit #(
   parameter int DELTA_BITS = vbme_pkg::DeltaBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  vbme_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output vbme_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vbme_pkg::ChanBits-1:0] csr_data
);
   import vbme_pkg::*;

   parse_state_type       state_ff, state_in;
   logic [DELTA_BITS-1:0] delta_ff, delta_in;
   logic [ChanBits-1:0]   channel_ff;
   burst_type             burst_ff, burst_in;
   burst_type             burst_new;
   logic                  req_fire;
   logic                  rsp_fire;
   logic [SlotCount-1:0]  lowest;
   logic [SlotCount-1:0]  rest;
   logic [3:0]            slot;
   logic                  last;

   vbme_parse #(
      .DELTA_BITS(DELTA_BITS)
   ) u_parse (
      .req_data     (req_data),
      .voice_channel(channel_ff),
      .state        (state_ff),
      .delta        (delta_ff),
      .state_next   (state_in),
      .delta_next   (delta_in),
      .burst        (burst_new)
   );

   // next byte is the lowest pending slot
   assign lowest = burst_ff.mask & (~burst_ff.mask + SlotCount'(1));
   assign rest   = burst_ff.mask & ~lowest;
   assign last   = (rest == '0);

   always_comb begin
      slot = 4'd0;
      for (int i = SlotCount - 1; i >= 0; i--) begin
         if (burst_ff.mask[i]) begin
            slot = 4'(i);
         end
      end
   end

   assign rsp_valid = (burst_ff.mask != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = !rsp_valid || (rsp_ready && last);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      case (slot)
         SlotEot0: rsp_data.out_byte = EotByte0;
         SlotEot1: rsp_data.out_byte = EotByte1;
         SlotEot2: rsp_data.out_byte = EotByte2;
         SlotEot3: rsp_data.out_byte = EotByte3;
         default:  rsp_data.out_byte = burst_ff.slot_byte[slot[2:0]];
      endcase
      rsp_data.last_of_run = last;
      rsp_data.error_code  = burst_ff.error_code;
      rsp_data.track_done  = (slot == SlotEot3);
   end

   always_comb begin
      burst_in = burst_ff;
      if (req_fire) begin
         burst_in = burst_new;        // empty mask when the byte makes no output
      end else if (rsp_fire) begin
         burst_in.mask = rest;
      end
   end

   // all-zero state is the skip-first-byte phase
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= '0;
         delta_ff            <= '0;
         channel_ff          <= '0;
         burst_ff            <= '0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
            delta_ff <= delta_in;
         end
         if (csr_valid && csr_ready) begin
            channel_ff <= csr_data;
         end
         burst_ff <= burst_in;
      end
   end

endmodule

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vbme_pkg::*;

   localparam int QuietLimit    = 1000;     // cycles with no transaction at all
   localparam int HoldCycles    = 200;      // long receiver hold-off
   localparam int SettleCycles  = 16;       // longer than one full 11-byte burst
   localparam int PhaseItems    = 75;       // minimum stream bytes queued per phase, four phases
   localparam int LongTimingRun = 70;       // 240 * this needs a three-group delta
   localparam logic [27:0] DeltaCap = 28'hfffffff;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_valid  = 1'b0;
   logic                req_ready;
   req_type             req_data   = '0;
   logic                rsp_valid;
   logic                rsp_ready  = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [ChanBits-1:0] csr_data   = '0;

   voice_bytes_to_midi_events_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // stimulus waiting to go out, and MIDI bytes still owed by the block
   req_type stream_q[$];
   rsp_type midi_exp_q[$];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_go       = 1'b0;   // toggled to request one long receiver hold-off
   int err_count     = 0;

   // ---------------------------------------------------------------------
   // Parser model: own copy of the channel register and the parse state.
   // ---------------------------------------------------------------------
   logic [ChanBits-1:0] chan_cfg    = '0;
   logic [2:0]          parse_at    = PhaseSkip;
   logic [27:0]         delta_acc   = '0;
   logic [7:0]          run_status  = '0;
   logic [7:0]          first_byte  = '0;
   logic                stream_done = 1'b0;
   int                  step_results;

   function automatic void emit(logic [7:0] b, logic [1:0] err, logic done);
      rsp_type r;
      r = '{out_byte: b, last_of_run: 1'b0, error_code: err, track_done: done};
      midi_exp_q.push_back(r);
      step_results++;
   endfunction

   function automatic void emit_error(logic [1:0] code);
      stream_done = 1'b1;
      emit(8'h00, code, 1'b0);
   endfunction

   function automatic void emit_track_end();
      emit(EotByte0, ErrNone, 1'b0);
      emit(EotByte1, ErrNone, 1'b0);
      emit(EotByte2, ErrNone, 1'b0);
      emit(EotByte3, ErrNone, 1'b1);
      stream_done = 1'b1;
   endfunction

   // variable-length delta, most significant group first, then status and data
   function automatic void emit_event(logic [7:0] st, logic [7:0] d1, logic [7:0] d2,
                                      bit with_d2);
      int          groups;
      logic [27:0] rest;
      groups = 1;
      while ((delta_acc >> (7 * groups)) != 0 && groups < 4)
         groups++;
      for (int g = groups - 1; g >= 0; g--) begin
         rest = delta_acc >> (7 * g);
         emit({1'(g > 0), rest[6:0]}, ErrNone, 1'b0);
      end
      emit(st, ErrNone, 1'b0);
      emit(d1, ErrNone, 1'b0);
      if (with_d2)
         emit(d2, ErrNone, 1'b0);
      delta_acc = '0;
      parse_at  = PhaseDeltaStart;
   endfunction

   // first data byte under the running status
   function automatic void take_first_data(logic [7:0] b);
      if (run_status[7:4] inside {HiNoteOn, HiControl, HiPitch}) begin
         first_byte = b;
         parse_at   = PhaseData2;
      end else if (run_status[7:4] == HiPatch) begin
         emit_event(run_status, b, 8'h00, 1'b0);
      end else begin
         emit_error(ErrNoStatus);
      end
   endfunction

   // Works out the MIDI bytes one accepted stream byte causes and queues them.
   function automatic void predict_midi(req_type it);
      logic [7:0]  b;
      logic [7:0]  st;
      logic [28:0] sum;
      rsp_type     r;
      b = it.in_byte;
      step_results = 0;
      if (it.voice_start) begin
         parse_at    = PhaseDeltaStart;
         delta_acc   = '0;
         run_status  = '0;
         first_byte  = '0;
         stream_done = 1'b0;
      end else if (stream_done) begin
         return;   // ended stream: silent until the next voice start
      end else begin
         case (parse_at)
            PhaseSkip: begin
               parse_at = PhaseDeltaStart;
            end
            PhaseDeltaStart, PhaseDeltaMore: begin
               sum = delta_acc + ((b == ByteTiming) ? 28'(TimingDelta) : 28'(b));
               delta_acc = (sum > DeltaCap) ? DeltaCap : sum[27:0];
               parse_at = (b == ByteTiming) ? PhaseDeltaMore : PhaseStatus;
            end
            PhaseStatus: begin
               if (b[7:4] inside {HiNoteOn, HiControl, HiPatch, HiPitch}) begin
                  if (b[3:0] != chan_cfg) begin
                     emit_error(ErrChannel);
                  end else begin
                     run_status = b;
                     parse_at   = PhaseData1;
                  end
               end else if (b == ByteEnd) begin
                  emit_track_end();
               end else begin
                  take_first_data(b);
               end
            end
            PhaseData1: begin
               take_first_data(b);
            end
            PhaseData2: begin
               st = run_status;
               if (st[7:4] == HiNoteOn && b == 8'h00)
                  st = {HiNoteOff, chan_cfg};   // zero velocity becomes note off
               emit_event(st, first_byte, b, 1'b1);
            end
            default: begin
               parse_at = PhaseDeltaStart;
            end
         endcase
      end
      // buffer end: clean between events, truncated inside one
      if (it.voice_end && !stream_done) begin
         if (parse_at == PhaseDeltaStart)
            emit_track_end();
         else
            emit_error(ErrTruncated);
      end
      if (step_results > 0) begin
         r = midi_exp_q.pop_back();
         r.last_of_run = 1'b1;
         midi_exp_q.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: presents queued stream bytes; predicts on each req transaction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_midi(req_data);
         if (!req_valid || req_ready) begin
            if (stream_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data  <= stream_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver back-pressure; a hold-off request blocks rsp while hold_left counts down.
   bit hold_seen = 1'b0;
   int hold_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_go) begin
         hold_seen <= hold_go;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Monitor: each rsp transaction against the oldest expected MIDI byte.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (midi_exp_q.size() == 0) begin
            $error("unexpected MIDI byte %02h", rsp_data.out_byte);
            err_count++;
         end else begin
            want = midi_exp_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_data.out_byte);
               err_count++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0b, got %0b",
                      want.last_of_run, rsp_data.last_of_run);
               err_count++;
            end
            if (rsp_data.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d",
                      want.error_code, rsp_data.error_code);
               err_count++;
            end
            if (rsp_data.track_done !== want.track_done) begin
               $error("track_done: expected %0b, got %0b",
                      want.track_done, rsp_data.track_done);
               err_count++;
            end
         end
      end
   end

   // Watchdog: any transaction on any channel restarts the count.
   int quiet = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QuietLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic req_type mk(logic [7:0] b, logic vs, logic ve);
      return '{in_byte: b, voice_start: vs, voice_end: ve};
   endfunction

   function automatic logic [7:0] data_byte();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 127));
   endfunction

   // any byte that the status phase reads as data (no status, no end marker)
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b[7:4] inside {HiNoteOn, HiControl, HiPatch, HiPitch} || b == ByteEnd);
      return b;
   endfunction

   // Queues one voice (mostly well formed, random content) or a burst of noise.
   // Returns the number of stream bytes queued.
   function automatic int queue_voice(logic [ChanBits-1:0] ch);
      req_type    v[$];
      req_type    tail;
      int         n_tim;
      int         kind;
      logic [3:0] hi;
      logic [3:0] cur_hi;
      logic [3:0] st_ch;
      bit         have_status;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(3, 8))
            v.push_back(mk(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                           $urandom_range(0, 5) == 0));
      end else begin
         v.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b0));   // skipped byte
         have_status = 1'b0;
         cur_hi      = HiNoteOn;
         repeat ($urandom_range(1, 6)) begin
            n_tim = $urandom_range(0, 19);
            n_tim = (n_tim < 12) ? 0 : (n_tim < 18) ? $urandom_range(1, 3)
                                                    : $urandom_range(60, 80);
            repeat (n_tim)
               v.push_back(mk(ByteTiming, 1'b0, 1'b0));
            v.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            kind = $urandom_range(0, 9);
            if (kind >= 5 && kind <= 7 && !have_status)
               kind = 0;
            if (kind <= 4) begin
               case (kind)
                  0, 1:    hi = HiNoteOn;
                  2:       hi = HiControl;
                  3:       hi = HiPatch;
                  default: hi = HiPitch;
               endcase
               st_ch = ($urandom_range(0, 11) == 0) ? ch ^ 4'($urandom_range(1, 15)) : ch;
               v.push_back(mk({hi, st_ch}, 1'b0, 1'b0));
               v.push_back(mk(data_byte(), 1'b0, 1'b0));
               have_status = 1'b1;
               cur_hi      = hi;
            end else if (kind <= 7) begin
               v.push_back(mk(plain_byte(), 1'b0, 1'b0));   // running status
            end else if (kind == 8) begin
               v.push_back(mk({HiNoteOn, ch}, 1'b0, 1'b0));
               v.push_back(mk(data_byte(), 1'b0, 1'b0));
               have_status = 1'b1;
               cur_hi      = HiNoteOn;
            end else begin
               v.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));   // broken
            end
            if (kind != 9 && cur_hi != HiPatch)
               v.push_back(mk(($urandom_range(0, 3) == 0) ? 8'h00 : data_byte(),
                              1'b0, 1'b0));
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               v.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
               v.push_back(mk(ByteEnd, 1'b0, 1'b0));
               if ($urandom_range(0, 1) == 1)
                  v.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            end
            4, 5, 6: begin
               tail = v.pop_back();
               tail.voice_end = 1'b1;
               v.push_back(tail);
            end
            7: begin
               v.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b1));   // cut short
            end
            default: ;   // next voice simply starts
         endcase
      end
      foreach (v[i])
         stream_q.push_back(v[i]);
      return v.size();
   endfunction

   task automatic wait_drained();
      while (stream_q.size() != 0 || req_valid || midi_exp_q.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_channel(logic [ChanBits-1:0] ch);
      csr_valid <= 1'b1;
      csr_data  <= ch;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      chan_cfg = ch;
   endtask

   task automatic run_phase(int idle_pct, int stall, logic [ChanBits-1:0] ch, bit hold);
      int n;
      wait_drained();
      write_channel(ch);
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      if (hold)
         hold_go = ~hold_go;
      n = 0;
      while (n < PhaseItems)
         n += queue_voice(ch);
   endtask

   initial begin
      logic [ChanBits-1:0] ch;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, channel 5
      ch = 4'd5;
      write_channel(ch);
      stream_q.push_back(mk(8'h00, 1'b0, 1'b0));           // skipped after reset
      stream_q.push_back(mk(ByteTiming, 1'b0, 1'b0));      // two timing bytes + 0x7f
      stream_q.push_back(mk(ByteTiming, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h7f, 1'b0, 1'b0));
      stream_q.push_back(mk({HiNoteOn, ch}, 1'b0, 1'b0));  // zero velocity: note off
      stream_q.push_back(mk(8'h3c, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h00, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h00, 1'b0, 1'b0));           // control
      stream_q.push_back(mk({HiControl, ch}, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h00, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h7f, 1'b0, 1'b0));
      stream_q.push_back(mk(8'hff, 1'b0, 1'b0));           // patch, extreme bytes
      stream_q.push_back(mk({HiPatch, ch}, 1'b0, 1'b0));
      stream_q.push_back(mk(8'hff, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h00, 1'b0, 1'b0));           // pitch, 0x80 as data
      stream_q.push_back(mk({HiPitch, ch}, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h80, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h40, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h00, 1'b0, 1'b0));           // end marker
      stream_q.push_back(mk(ByteEnd, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h55, 1'b0, 1'b0));           // ignored once ended
      stream_q.push_back(mk(8'hff, 1'b1, 1'b1));           // start and end together
      stream_q.push_back(mk(8'h00, 1'b1, 1'b0));           // wrong channel
      stream_q.push_back(mk(8'h00, 1'b0, 1'b0));
      stream_q.push_back(mk({HiNoteOn, ~ch}, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h00, 1'b1, 1'b0));           // data with no status
      stream_q.push_back(mk(8'h00, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h12, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h00, 1'b1, 1'b0));           // buffer ends mid event
      stream_q.push_back(mk(8'h00, 1'b0, 1'b1));

      // long delta: three-group delta, event plus track end in one step
      stream_q.push_back(mk(8'h00, 1'b1, 1'b0));
      for (int i = 0; i < LongTimingRun; i++)
         stream_q.push_back(mk(ByteTiming, 1'b0, 1'b0));
      stream_q.push_back(mk(8'hff, 1'b0, 1'b0));
      stream_q.push_back(mk({HiNoteOn, ch}, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h7f, 1'b0, 1'b0));
      stream_q.push_back(mk(8'h7f, 1'b0, 1'b1));

      // random phases: no idling, sender idle, receiver stall with hold-off, both
      run_phase(0, 0, 4'd0, 1'b0);
      run_phase(63, 0, 4'd15, 1'b0);
      run_phase(0, 63, 4'($urandom_range(0, 15)), 1'b1);
      run_phase(28, 28, 4'($urandom_range(0, 15)), 1'b0);

      wait_drained();
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
